### hw/rtl/complex_q15_fir_filter_assert.svh
// ----------------------------------------------------------------------------
// complex_q15_fir_filter assertion macros
// Shared property macros for the checker of the complex FIR filter.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_Q15_FIR_FILTER_ASSERT_SVH
`define COMPLEX_Q15_FIR_FILTER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CQF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CQF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cqf_pkg.sv
// ----------------------------------------------------------------------------
// cqf_pkg
// Types and constants shared by the complex Q15 FIR filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cqf_pkg;

  localparam int unsigned MAX_TAPS_DEF = 64;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned TAP_INDEX_W  = 6;
  localparam int unsigned TAP_SLOTS    = 2 ** TAP_INDEX_W;
  localparam int unsigned TAP_COUNT_W  = 7;

  // bit-mode level: peak level divided down
  localparam int BIT_PEAK = 25000;
  localparam int BIT_DIV  = 8;
  localparam logic signed [SAMPLE_W-1:0] BIT_LEVEL = SAMPLE_W'(BIT_PEAK / BIT_DIV);

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;

  // item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // config port
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_TAP_COUNT = 1'b0;
  localparam logic REG_BIT_MODE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic                   shift;
    logic                   clear;
    logic                   load;
    logic [TAP_INDEX_W-1:0] tap_index;
  } cell_ctrl_t;

endpackage

### hw/rtl/cqf_cell.sv
// ----------------------------------------------------------------------------
// cqf_cell
// One tap of the filter: tap, history stage, complex product, partial sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cqf_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7,
  parameter int unsigned ACC_W = 39
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cqf_pkg::cell_ctrl_t            ctrl,
  input  logic signed [cqf_pkg::SAMPLE_W-1:0] tap_real_in,
  input  logic signed [cqf_pkg::SAMPLE_W-1:0] tap_imag_in,
  input  logic signed [cqf_pkg::SAMPLE_W-1:0] hist_real_in,
  input  logic signed [cqf_pkg::SAMPLE_W-1:0] hist_imag_in,
  input  logic [CNT_W-1:0]               n_eff,
  input  logic signed [ACC_W-1:0]        acc_real_in,
  input  logic signed [ACC_W-1:0]        acc_imag_in,
  output logic signed [cqf_pkg::SAMPLE_W-1:0] hist_real,
  output logic signed [cqf_pkg::SAMPLE_W-1:0] hist_imag,
  output logic signed [ACC_W-1:0]        acc_real_out,
  output logic signed [ACC_W-1:0]        acc_imag_out
);
  import cqf_pkg::*;

  localparam int unsigned PROD_W = 2 * SAMPLE_W;

  logic signed [SAMPLE_W-1:0] tap_real;
  logic signed [SAMPLE_W-1:0] tap_imag;
  logic signed [PROD_W-1:0]   p_rr, p_ii, p_ri, p_ir;
  logic signed [PROD_W:0]     comb_real, comb_imag;
  logic                       load_hit;
  logic                       use_tap;

  assign load_hit = (IDX < TAP_SLOTS) && (ctrl.tap_index == TAP_INDEX_W'(IDX));
  assign use_tap  = CNT_W'(IDX) < n_eff;

  // tap and history storage
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_real  <= '0;
      tap_imag  <= '0;
      hist_real <= '0;
      hist_imag <= '0;
    end else begin
      if (ctrl.load && load_hit) begin
        tap_real <= tap_real_in;
        tap_imag <= tap_imag_in;
      end
      if (ctrl.shift) begin
        if (ctrl.clear && IDX != 0) begin
          hist_real <= '0;
          hist_imag <= '0;
        end else begin
          hist_real <= hist_real_in;
          hist_imag <= hist_imag_in;
        end
      end
    end
  end

  // multiply, combine, then add into the passing partial sum
  always_ff @(posedge clk) begin
    p_rr      <= tap_real * hist_real;
    p_ii      <= tap_imag * hist_imag;
    p_ri      <= tap_real * hist_imag;
    p_ir      <= tap_imag * hist_real;
    comb_real <= (PROD_W + 1)'(p_rr) - (PROD_W + 1)'(p_ii);
    comb_imag <= (PROD_W + 1)'(p_ri) + (PROD_W + 1)'(p_ir);
    acc_real_out <= acc_real_in + (use_tap ? ACC_W'(comb_real) : '0);
    acc_imag_out <= acc_imag_in + (use_tap ? ACC_W'(comb_imag) : '0);
  end

endmodule

### hw/rtl/complex_q15_fir_filter.sv
// ----------------------------------------------------------------------------
// complex_q15_fir_filter
// Streaming complex FIR filter with Q15 taps and a bit-mode sample source.
// ----------------------------------------------------------------------------
// A tap-load item is taken without stalling the input and gives no result.
// For a sample item, the sample shifts into the history chain, every cell
// registers its complex product, and the partial sum then travels down the
// chain of cells one cell per clock before the last cell's sum is scaled
// and registered at the output. One sample is in flight at a time and the
// input stalls until its result is registered; if an older result still
// waits in the output register when the run ends, the input stays stalled
// until that result is taken. A finished result may wait in the output
// register while the next item is taken. The result is the sum of h[k]*x[n-k]
// over the active taps, shifted right by 15 (floor), low 16 bits kept, with
// overflow set when either part did not fit. tap_count of 0 acts as 1 and
// values above MAX_TAPS act as MAX_TAPS. Write configuration only while idle.
`timescale 1ns / 1ps

module complex_q15_fir_filter #(
  parameter int unsigned MAX_TAPS = cqf_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cqf_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // input items
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic                                 func,
  input  logic [cqf_pkg::TAP_INDEX_W-1:0]      tap_index,
  input  logic signed [cqf_pkg::SAMPLE_W-1:0]  value_real,
  input  logic signed [cqf_pkg::SAMPLE_W-1:0]  value_imag,
  input  logic                                 data_bit,
  input  logic                                 clear_history,
  input  logic                                 block_end,
  // result items
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [cqf_pkg::SAMPLE_W-1:0]  out_real,
  output logic signed [cqf_pkg::SAMPLE_W-1:0]  out_imag,
  output logic                                 overflow,
  output logic                                 last
);
  import cqf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TAPS + 1);
  localparam int unsigned ACC_W = 2 * SAMPLE_W + 1 + $clog2(MAX_TAPS);
  localparam int unsigned LAT   = MAX_TAPS + 3;
  localparam int unsigned LAT_W = $clog2(LAT);
  // bit where the shifted sum's sign must start to fit in 16 bits
  localparam int unsigned TOP_B = 2 * SAMPLE_W - 2;

  // configuration registers
  logic [TAP_COUNT_W-1:0] tap_count;
  logic                   bit_mode;
  logic                   cfg_write;
  logic [CNT_W-1:0]       n_eff;

  // control
  state_t             state, state_next;
  logic [LAT_W-1:0]   cnt;
  logic               accept;
  logic               take_sample;
  logic               done;
  logic               out_free;
  logic               capture;
  logic               last_hold;
  cell_ctrl_t         ctrl;

  // datapath
  logic signed [SAMPLE_W-1:0] smp_real, smp_imag;
  logic signed [SAMPLE_W-1:0] hist_real [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_imag [MAX_TAPS];
  logic signed [ACC_W-1:0]    acc_real  [MAX_TAPS];
  logic signed [ACC_W-1:0]    acc_imag  [MAX_TAPS];
  logic signed [ACC_W-1:0]    sum_real, sum_imag;
  logic                       fits_real, fits_imag;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
      bit_mode  <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_TAP_COUNT: tap_count <= pwdata[TAP_COUNT_W-1:0];
        REG_BIT_MODE:  bit_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TAP_COUNT: prdata = 32'(tap_count);
      REG_BIT_MODE:  prdata = 32'(bit_mode);
      default:       prdata = '0;
    endcase
  end

  // clamp the tap count into 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(tap_count) > 32'(MAX_TAPS)) begin
      n_eff = CNT_W'(MAX_TAPS);
    end else begin
      n_eff = CNT_W'(tap_count);
    end
  end

  // --------------------------------------------------------------- control
  assign accept      = sample_valid && !sample_stall;
  assign take_sample = accept && (func == FUNC_SAMPLE);
  assign done        = (state == ST_RUN) && (cnt == LAT_W'(LAT - 1));
  assign out_free    = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take_sample) state_next = ST_RUN;
      ST_RUN:  if (done) state_next = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_stall = (state != ST_IDLE);
    capture      = (done || (state == ST_HOLD)) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      // count cycles of the partial-sum wave
      if (take_sample) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + LAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) last_hold <= block_end;
  end

  // broadcast to the cells
  assign ctrl.shift     = take_sample;
  assign ctrl.clear     = clear_history;
  assign ctrl.load      = accept && (func == FUNC_LOAD);
  assign ctrl.tap_index = tap_index;

  // bit mode replaces the sample with a real level of plus or minus 3125
  always_comb begin
    if (bit_mode) begin
      smp_real = data_bit ? BIT_LEVEL : -BIT_LEVEL;
      smp_imag = '0;
    end else begin
      smp_real = value_real;
      smp_imag = value_imag;
    end
  end

  // -------------------------------------------------------------- the chain
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] h_real_in, h_imag_in;
    logic signed [ACC_W-1:0]    a_real_in, a_imag_in;

    if (k == 0) begin : g_head
      assign h_real_in = smp_real;
      assign h_imag_in = smp_imag;
      assign a_real_in = '0;
      assign a_imag_in = '0;
    end else begin : g_body
      assign h_real_in = hist_real[k-1];
      assign h_imag_in = hist_imag[k-1];
      assign a_real_in = acc_real[k-1];
      assign a_imag_in = acc_imag[k-1];
    end

    cqf_cell #(
      .IDX   (k),
      .CNT_W (CNT_W),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .tap_real_in  (value_real),
      .tap_imag_in  (value_imag),
      .hist_real_in (h_real_in),
      .hist_imag_in (h_imag_in),
      .n_eff        (n_eff),
      .acc_real_in  (a_real_in),
      .acc_imag_in  (a_imag_in),
      .hist_real    (hist_real[k]),
      .hist_imag    (hist_imag[k]),
      .acc_real_out (acc_real[k]),
      .acc_imag_out (acc_imag[k])
    );
  end

  // ---------------------------------------------------------------- output
  assign sum_real = acc_real[MAX_TAPS-1];
  assign sum_imag = acc_imag[MAX_TAPS-1];

  // shifted value fits 16 bits when all bits from TOP_B up agree
  assign fits_real = (&sum_real[ACC_W-1:TOP_B]) || !(|sum_real[ACC_W-1:TOP_B]);
  assign fits_imag = (&sum_imag[ACC_W-1:TOP_B]) || !(|sum_imag[ACC_W-1:TOP_B]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (capture) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_real <= sum_real[TOP_B:SAMPLE_W-1];
      out_imag <= sum_imag[TOP_B:SAMPLE_W-1];
      overflow <= !(fits_real && fits_imag);
      last     <= last_hold;
    end
  end

endmodule

### hw/rtl/cqf_checker.sv
// ----------------------------------------------------------------------------
// cqf_checker
// Port-level checks of the complex FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "complex_q15_fir_filter_assert.svh"

module cqf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_stall,
  input logic                                func,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic signed [cqf_pkg::SAMPLE_W-1:0] out_real,
  input logic signed [cqf_pkg::SAMPLE_W-1:0] out_imag,
  input logic                                overflow,
  input logic                                last
);
  import cqf_pkg::*;

  // a stalled result holds
  `CQF_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(out_real) && $stable(out_imag) && $stable(overflow) && $stable(last), "stalled result changed")

  // a sample item starts a run
  `CQF_ASSERT_NEXT(a_sample_busy, clk, rst, sample_valid && !sample_stall && func == FUNC_SAMPLE, sample_stall, "sample item did not start a run")

  // a tap load does not stall the input
  `CQF_ASSERT_NEXT(a_load_quick, clk, rst, sample_valid && !sample_stall && func == FUNC_LOAD, !sample_stall, "tap load stalled the input")

  // a result appears only at the end of a run
  `CQF_ASSERT_SAME(a_result_src, clk, rst, $rose(result_valid), $past(sample_stall), "result without a run")

endmodule

bind complex_q15_fir_filter cqf_checker u_cqf_checker (.*);
